// ----- hdl/cmt_pkg.sv -----
// Shared types and constants for the Carmichael number test core.
// Used by cmt_modmul, cmt_datapath, cmt_ctrl and carmichael_number_test_core.
`timescale 1ns / 1ps

package cmt_pkg;

  localparam int MAX_N_DEF = 65536;
  localparam int NUM_W     = 16;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int WORD_W    = 32;

  typedef enum logic [1:0] {
    ASEL_CLR,
    ASEL_I,
    ASEL_J,
    ASEL_N
  } addr_sel_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      clr_wr;
    logic      j_wr;
    logic      i_next;
    logic      j_load;
    logic      j_next;
    logic      n_load;
    logic      a_init;
    logic      a_inc;
    logic      exp_init;
    logic      mul_ab;
    logic      mul_bb;
    logic      acc_ld;
    logic      b_ld_shift;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic i_done;
    logic i_bit;
    logic j_done;
    logic n_ok;
    logic n_two;
    logic n_odd;
    logic n_bit;
    logic a_eq_n;
    logic e_zero;
    logic e_lsb;
    logic acc_eq_a;
    logic mul_done;
  } status_t;

endpackage

// ----- hdl/cmt_modmul.sv -----
// Iterative modular multiplier: x*y mod m, one multiplier bit per cycle.
// Depends on cmt_pkg for widths. Requires y < m.
`timescale 1ns / 1ps

module cmt_modmul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cmt_pkg::NUM_W-1:0] x,
  input  logic [cmt_pkg::NUM_W-1:0] y,
  input  logic [cmt_pkg::NUM_W-1:0] m,
  output logic [cmt_pkg::NUM_W-1:0] res,
  output logic                      done
);

  logic                      run_r;
  logic                      done_r;
  logic [cmt_pkg::CNT_W-1:0] cnt_r;
  logic [cmt_pkg::NUM_W-1:0] r_r;
  logic [cmt_pkg::NUM_W-1:0] x_r;

  logic [cmt_pkg::NUM_W:0]   m_ext;
  logic [cmt_pkg::NUM_W:0]   t1;
  logic [cmt_pkg::NUM_W:0]   t1r;
  logic [cmt_pkg::NUM_W:0]   t2;
  logic [cmt_pkg::NUM_W:0]   t2r;
  logic [cmt_pkg::NUM_W-1:0] r_nxt;

  // Horner step: r = 2r + bit*y, each partial result kept below m.
  always_comb begin
    m_ext = {1'b0, m};
    t1    = {r_r, 1'b0};
    t1r   = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    t2    = t1r + (x_r[cmt_pkg::NUM_W-1] ? {1'b0, y} : '0);
    t2r   = (t2 >= m_ext) ? (t2 - m_ext) : t2;
    r_nxt = t2r[cmt_pkg::NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= cmt_pkg::CNT_W'(cmt_pkg::NUM_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - cmt_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= '0;
      x_r <= x;
    end else if (run_r) begin
      r_r <= r_nxt;
      x_r <= {x_r[cmt_pkg::NUM_W-2:0], 1'b0};
    end
  end

  assign res  = r_r;
  assign done = done_r;

endmodule

// ----- hdl/cmt_datapath.sv -----
// Datapath: sieve memory, sieve counters, Fermat test registers and modular multiplier.
// Depends on cmt_pkg and cmt_modmul; driven by commands from cmt_ctrl.
`timescale 1ns / 1ps

module cmt_datapath #(
  parameter int MAX_N = cmt_pkg::MAX_N_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cmt_pkg::NUM_W-1:0] in_number,
  input  cmt_pkg::cmd_t             cmd,
  output cmt_pkg::status_t          st
);

  localparam int WORDS = (MAX_N + 63) / 64;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int KW    = $clog2(MAX_N) + 1;

  logic [cmt_pkg::WORD_W-1:0] mem [WORDS];
  logic [cmt_pkg::WORD_W-1:0] rd_data_r;
  logic [cmt_pkg::WORD_W-1:0] wr_data;
  logic [AW-1:0]              addr;
  logic                       wr_en;

  logic [AW-1:0]              clr_r;
  logic [KW-1:0]              i_r;
  logic [KW-1:0]              sq_r;
  logic [KW-1:0]              j_r;
  logic [KW-1:0]              nk;

  logic [cmt_pkg::NUM_W-1:0]  n_r;
  logic [cmt_pkg::NUM_W-1:0]  a_r;
  logic [cmt_pkg::NUM_W-1:0]  acc_r;
  logic [cmt_pkg::NUM_W-1:0]  b_r;
  logic [cmt_pkg::NUM_W-1:0]  e_r;

  logic                       mul_start;
  logic [cmt_pkg::NUM_W-1:0]  mul_x;
  logic [cmt_pkg::NUM_W-1:0]  mul_res;
  logic                       mul_done;

  assign nk = KW'(n_r);

  always_comb begin
    unique case (cmd.addr_sel)
      cmt_pkg::ASEL_I: addr = i_r[AW+5:6];
      cmt_pkg::ASEL_J: addr = j_r[AW+5:6];
      cmt_pkg::ASEL_N: addr = nk[AW+5:6];
      default:         addr = clr_r;
    endcase
  end

  assign wr_en   = cmd.clr_wr | cmd.j_wr;
  assign wr_data = cmd.clr_wr ? '1
                 : (rd_data_r & ~(cmt_pkg::WORD_W'(1) << j_r[5:1]));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  // Sieve counters: sq_r tracks i*i, updated by (i+2)^2 = i^2 + 4i + 4.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      i_r   <= KW'(3);
      sq_r  <= KW'(9);
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.i_next) begin
        i_r  <= i_r + KW'(2);
        sq_r <= sq_r + (i_r << 2) + KW'(4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.j_load) begin
      j_r <= sq_r;
    end else if (cmd.j_next) begin
      j_r <= j_r + (i_r << 1);
    end
    if (cmd.n_load) begin
      n_r <= in_number;
    end
    if (cmd.a_init) begin
      a_r <= cmt_pkg::NUM_W'(2);
    end else if (cmd.a_inc) begin
      a_r <= a_r + cmt_pkg::NUM_W'(1);
    end
    if (cmd.exp_init) begin
      acc_r <= cmt_pkg::NUM_W'(1);
      b_r   <= a_r;
      e_r   <= n_r;
    end else begin
      if (cmd.acc_ld) begin
        acc_r <= mul_res;
      end
      if (cmd.b_ld_shift) begin
        b_r <= mul_res;
        e_r <= e_r >> 1;
      end
    end
  end

  assign mul_start = cmd.mul_ab | cmd.mul_bb;
  assign mul_x     = cmd.mul_ab ? acc_r : b_r;

  cmt_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (b_r),
    .m     (n_r),
    .res   (mul_res),
    .done  (mul_done)
  );

  always_comb begin
    st.clr_last = (clr_r == AW'(WORDS - 1));
    st.i_done   = (sq_r >= KW'(MAX_N));
    st.i_bit    = rd_data_r[i_r[5:1]];
    st.j_done   = (j_r >= KW'(MAX_N));
    st.n_ok     = (n_r != '0) && ({16'b0, n_r} < 32'(MAX_N));
    st.n_two    = (n_r == cmt_pkg::NUM_W'(2));
    st.n_odd    = n_r[0];
    st.n_bit    = rd_data_r[n_r[5:1]];
    st.a_eq_n   = (a_r == n_r);
    st.e_zero   = (e_r == '0);
    st.e_lsb    = e_r[0];
    st.acc_eq_a = (acc_r == a_r);
    st.mul_done = mul_done;
  end

endmodule

// ----- hdl/cmt_ctrl.sv -----
// Controller: sieve build after reset, then per transaction the Fermat test sequence.
// Depends on cmt_pkg; drives cmt_datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps

module cmt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  cmt_pkg::status_t st,
  output cmt_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             out_valid,
  output logic             out_flag
);

  typedef enum logic [3:0] {
    S_CLR,
    S_SV_I,
    S_SV_IC,
    S_SV_J,
    S_SV_JW,
    S_IDLE,
    S_N_RD,
    S_N_CHK,
    S_BASE,
    S_EXP,
    S_MUL_A,
    S_MUL_B
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;
  logic   flag_r, flag_nxt;

  always_comb begin
    cmd       = '0;
    cmd.addr_sel = cmt_pkg::ASEL_CLR;
    state_nxt = state_r;
    valid_nxt = 1'b0;
    flag_nxt  = flag_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_nxt = S_SV_I;
      end
      S_SV_I: begin
        cmd.addr_sel = cmt_pkg::ASEL_I;
        state_nxt    = st.i_done ? S_IDLE : S_SV_IC;
      end
      S_SV_IC: begin
        if (st.i_bit) begin
          cmd.j_load = 1'b1;
          state_nxt  = S_SV_J;
        end else begin
          cmd.i_next = 1'b1;
          state_nxt  = S_SV_I;
        end
      end
      S_SV_J: begin
        cmd.addr_sel = cmt_pkg::ASEL_J;
        if (st.j_done) begin
          cmd.i_next = 1'b1;
          state_nxt  = S_SV_I;
        end else begin
          state_nxt = S_SV_JW;
        end
      end
      S_SV_JW: begin
        cmd.addr_sel = cmt_pkg::ASEL_J;
        cmd.j_wr     = 1'b1;
        cmd.j_next   = 1'b1;
        state_nxt    = S_SV_J;
      end
      S_IDLE: begin
        if (start) begin
          cmd.n_load = 1'b1;
          state_nxt  = S_N_RD;
        end
      end
      S_N_RD: begin
        cmd.addr_sel = cmt_pkg::ASEL_N;
        if (st.n_ok) begin
          state_nxt = S_N_CHK;
        end else begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_N_CHK: begin
        // Two and odd numbers still marked in the sieve are prime.
        if (st.n_two || (st.n_odd && st.n_bit)) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cmd.a_init = 1'b1;
          state_nxt  = S_BASE;
        end
      end
      S_BASE: begin
        if (st.a_eq_n) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.exp_init = 1'b1;
          state_nxt    = S_EXP;
        end
      end
      S_EXP: begin
        if (st.e_zero) begin
          if (st.acc_eq_a) begin
            cmd.a_inc = 1'b1;
            state_nxt = S_BASE;
          end else begin
            valid_nxt = 1'b1;
            flag_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end else if (st.e_lsb) begin
          cmd.mul_ab = 1'b1;
          state_nxt  = S_MUL_A;
        end else begin
          cmd.mul_bb = 1'b1;
          state_nxt  = S_MUL_B;
        end
      end
      S_MUL_A: begin
        if (st.mul_done) begin
          cmd.acc_ld = 1'b1;
          cmd.mul_bb = 1'b1;
          state_nxt  = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (st.mul_done) begin
          cmd.b_ld_shift = 1'b1;
          state_nxt      = S_EXP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      valid_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_flag  = flag_r;

endmodule

// ----- hdl/carmichael_number_test_core.sv -----
// Top level of the Carmichael number test core.
// Depends on cmt_pkg, cmt_ctrl, cmt_datapath (which holds cmt_modmul).
//
//   channel | ports                          | handshake
//   --------+--------------------------------+---------------------------------
//   input   | in_number[15:0]                | accepted when start && !busy
//   result  | out_is_carmichael              | valid for one cycle on out_valid
//
// After reset the sieve memory is first filled with ones, one word a cycle, then
// sieved; busy stays high meanwhile. The result strobe is set by the range
// check state for zero or a number not below MAX_N, and by the sieve check
// state for two or a number marked prime. Otherwise each base tried is raised to
// the power of the number by square and multiply over its bits, each product
// taken in the serial modular multiplier; testing stops at the first failing
// base. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps

module carmichael_number_test_core #(
  parameter int MAX_N = cmt_pkg::MAX_N_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [cmt_pkg::NUM_W-1:0] in_number,
  output logic                      out_valid,
  output logic                      out_is_carmichael
);

  cmt_pkg::cmd_t    cmd;
  cmt_pkg::status_t st;

  cmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_flag  (out_is_carmichael)
  );

  cmt_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_number (in_number),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
